// ----- hdl/btrr_pkg.sv -----
`timescale 1ns / 1ps
package btrr_pkg;

  localparam int DEF_MAX_GLYPH_ROWS = 16;
  localparam int DEF_GLYPH_COUNT    = 256;
  localparam int DEF_COORD_BITS     = 16;

  localparam int STORE_DEPTH = 8192;
  localparam int ADDR_BITS   = 13;
  localparam int ROW_LIMIT   = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [4:0] NARROW_LIMIT = 5'd8;
  localparam logic [4:0] WIDE_LIMIT   = 5'd16;

  localparam logic [4:0]  RST_FONT_HEIGHT   = 5'd16;
  localparam logic [4:0]  RST_FONT_WIDTH    = 5'd8;
  localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [31:0] RST_INK_COLOR     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CHAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_FONT_HEIGHT   = 3'd0,
    REG_FONT_WIDTH    = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_INK_COLOR     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_ROWS,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic write_byte;
    logic set_origin;
    logic newline;
    logic step_x;
    logic capture;
    logic setup;
    logic issue_en;
  } cmd_t;

  typedef struct packed {
    logic glyph_ok;
    logic rows_done;
    logic pipe_busy;
  } stat_t;

endpackage

// ----- hdl/btrr_ctrl.sv -----
`timescale 1ns / 1ps
module btrr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        operation,
  input  logic [7:0]        char_code,
  input  btrr_pkg::stat_t   stat,
  output btrr_pkg::cmd_t    cmd,
  output logic              in_stall
);

  btrr_pkg::state_t state, state_next;
  logic accept;

  assign accept = in_valid && (state == btrr_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btrr_pkg::S_IDLE: begin
        if (accept && (btrr_pkg::op_t'(operation) == btrr_pkg::OP_CHAR) &&
            (char_code != btrr_pkg::NEWLINE_CODE) && stat.glyph_ok) begin
          state_next = btrr_pkg::S_SETUP;
        end
      end
      btrr_pkg::S_SETUP: state_next = btrr_pkg::S_ROWS;
      btrr_pkg::S_ROWS: begin
        if (stat.rows_done) state_next = btrr_pkg::S_DRAIN;
      end
      btrr_pkg::S_DRAIN: begin
        if (!stat.pipe_busy) state_next = btrr_pkg::S_IDLE;
      end
      default: state_next = btrr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      btrr_pkg::S_IDLE: begin
        if (accept) begin
          case (operation)
            btrr_pkg::OP_LOAD:  cmd.write_byte = 1'b1;
            btrr_pkg::OP_START: cmd.set_origin = 1'b1;
            btrr_pkg::OP_CHAR: begin
              if (char_code == btrr_pkg::NEWLINE_CODE) cmd.newline = 1'b1;
              else if (stat.glyph_ok) cmd.capture = 1'b1;
              else cmd.step_x = 1'b1;
            end
            default: ;
          endcase
        end
      end
      btrr_pkg::S_SETUP: cmd.setup = 1'b1;
      btrr_pkg::S_ROWS:  cmd.issue_en = 1'b1;
      btrr_pkg::S_DRAIN: ;
      default: ;
    endcase
  end

  assign in_stall = (state != btrr_pkg::S_IDLE);

endmodule

// ----- hdl/btrr_datapath.sv -----
`timescale 1ns / 1ps
module btrr_datapath #(
  parameter int MAX_GLYPH_ROWS = btrr_pkg::DEF_MAX_GLYPH_ROWS,
  parameter int GLYPH_COUNT    = btrr_pkg::DEF_GLYPH_COUNT,
  parameter int COORD_BITS     = btrr_pkg::DEF_COORD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  btrr_pkg::cmd_t      cmd,
  output btrr_pkg::stat_t     stat,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [12:0]         font_addr,
  input  logic [7:0]          font_byte,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  input  logic [7:0]          char_code,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         row_y,
  output logic signed [15:0]  row_x,
  output logic [15:0]         pixel_mask,
  output logic [31:0]         color,
  output logic                last_row
);

  localparam int ROW_CAP = (MAX_GLYPH_ROWS < btrr_pkg::ROW_LIMIT) ?
                           MAX_GLYPH_ROWS : btrr_pkg::ROW_LIMIT;
  localparam int RCW = $clog2(ROW_CAP + 1);
  localparam int YW  = COORD_BITS + 2;
  localparam int AW  = btrr_pkg::ADDR_BITS;
  localparam logic signed [YW-1:0] Y_MAX = YW'(4095);

  // configuration
  logic [4:0]  font_height, font_width;
  logic [12:0] screen_width, screen_height;
  logic [31:0] ink_color;

  // cursor
  logic [COORD_BITS-1:0] cursor_x, cursor_y, origin_x;

  // per character
  logic [7:0]            code_q;
  logic [COORD_BITS-1:0] x0_q, y0_q;
  logic                  wide_q;
  logic [15:0]           clip_q;
  logic [RCW-1:0]        rows_total, row_cnt;
  logic [AW-1:0]         addr;

  // read stage
  logic        p1_valid, p1_last;
  logic [11:0] p1_y;
  logic [7:0]  rd0, rd1;

  logic [7:0] store [btrr_pkg::STORE_DEPTH];

  logic                  adv, issue;
  logic [AW-1:0]         prod;
  logic [AW-1:0]         addr_hi;
  logic signed [YW-1:0]  y_row, y_nxt;
  logic [15:0]           clip_next;
  logic [RCW-1:0]        rows_next;
  logic signed [31:0]    sx32, sy32;
  logic [31:0]           x0_ext;

  function automatic logic row_vis(input logic signed [YW-1:0] y,
                                   input logic [12:0] sh);
    return (y >= 0) && (y < $signed(YW'(sh))) && (y <= Y_MAX);
  endfunction

  assign stat.glyph_ok  = (font_width <= btrr_pkg::WIDE_LIMIT) &&
                          ({1'b0, char_code} < 9'(GLYPH_COUNT));
  assign stat.rows_done = (row_cnt == rows_total);
  assign stat.pipe_busy = p1_valid;

  assign adv   = !out_valid || !out_stall;
  assign issue = cmd.issue_en && adv && (row_cnt != rows_total);

  assign prod    = AW'({5'd0, code_q} * {8'd0, font_height});
  assign addr_hi = addr + AW'(1);
  assign y_row   = YW'($signed(y0_q)) + $signed(YW'(row_cnt));
  assign y_nxt   = y_row + $signed(YW'(1));
  assign rows_next = (font_height > 5'(ROW_CAP)) ? RCW'(ROW_CAP) : RCW'(font_height);
  assign sx32    = 32'(start_x);
  assign sy32    = 32'(start_y);
  assign x0_ext  = 32'(x0_q);

  always_comb begin
    logic signed [YW-1:0] col;
    for (int i = 0; i < 16; i++) begin
      col = YW'($signed(x0_q)) + $signed(YW'(i));
      clip_next[15-i] = (col >= 0) && (col < $signed(YW'(screen_width)));
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      font_height   <= btrr_pkg::RST_FONT_HEIGHT;
      font_width    <= btrr_pkg::RST_FONT_WIDTH;
      screen_width  <= btrr_pkg::RST_SCREEN_WIDTH;
      screen_height <= btrr_pkg::RST_SCREEN_HEIGHT;
      ink_color     <= btrr_pkg::RST_INK_COLOR;
    end else if (cfg_write) begin
      unique case (btrr_pkg::reg_idx_t'(cfg_index))
        btrr_pkg::REG_FONT_HEIGHT:   font_height   <= cfg_data[4:0];
        btrr_pkg::REG_FONT_WIDTH:    font_width    <= cfg_data[4:0];
        btrr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        btrr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        btrr_pkg::REG_INK_COLOR:     ink_color     <= cfg_data;
        default: ;
      endcase
    end
  end

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      origin_x <= '0;
    end else if (cmd.set_origin) begin
      cursor_x <= sx32[COORD_BITS-1:0];
      cursor_y <= sy32[COORD_BITS-1:0];
      origin_x <= sx32[COORD_BITS-1:0];
    end else if (cmd.newline) begin
      cursor_x <= origin_x;
      cursor_y <= cursor_y + COORD_BITS'(font_height);
    end else if (cmd.step_x || cmd.capture) begin
      cursor_x <= cursor_x + COORD_BITS'(font_width);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_q <= char_code;
      x0_q   <= cursor_x;
      y0_q   <= cursor_y;
      wide_q <= (font_width > btrr_pkg::NARROW_LIMIT);
    end
    if (cmd.setup) begin
      addr   <= wide_q ? {prod[AW-2:0], 1'b0} : prod;
      clip_q <= clip_next;
    end else if (issue) begin
      addr <= addr + (wide_q ? AW'(2) : AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt    <= '0;
      rows_total <= '0;
    end else if (cmd.setup) begin
      row_cnt    <= '0;
      rows_total <= rows_next;
    end else if (issue) begin
      row_cnt <= row_cnt + RCW'(1);
    end
  end

  // glyph store, two read ports for wide rows
  always_ff @(posedge clk) begin
    if (cmd.write_byte) store[font_addr] <= font_byte;
    if (issue) begin
      rd0 <= store[addr];
      rd1 <= store[addr_hi];
    end
  end

  // read stage then output register, both held while the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= issue && row_vis(y_row, screen_height);
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_y    <= y_row[11:0];
      p1_last <= (row_cnt == rows_total - RCW'(1)) || !row_vis(y_nxt, screen_height);
    end
    if (adv && p1_valid) begin
      row_y      <= p1_y;
      row_x      <= x0_ext[15:0];
      pixel_mask <= (wide_q ? {rd0, rd1} : {rd0, 8'h00}) & clip_q;
      color      <= ink_color;
      last_row   <= p1_last;
    end
  end

endmodule

// ----- hdl/bitmap_text_row_renderer.sv -----
`timescale 1ns / 1ps
// load, start, newline and undrawable character requests never stall the input
// a drawable character request stalls the input through the setup, row read and drain
// states and reads rows = min(font_height, MAX_GLYPH_ROWS, 16) glyph rows;
// the glyph store is read one row per cycle while the output does not stall
// output stalls hold the row read loop, an invisible row is still read but not output
// reset (synchronous, active high) clears cursor, origin, pipeline and restores registers;
// the glyph store is not cleared and must be loaded before use
module bitmap_text_row_renderer #(
  parameter int MAX_GLYPH_ROWS = btrr_pkg::DEF_MAX_GLYPH_ROWS,
  parameter int GLYPH_COUNT    = btrr_pkg::DEF_GLYPH_COUNT,
  parameter int COORD_BITS     = btrr_pkg::DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [12:0]        font_addr,
  input  logic [7:0]         font_byte,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        row_y,
  output logic signed [15:0] row_x,
  output logic [15:0]        pixel_mask,
  output logic [31:0]        color,
  output logic               last_row
);

  btrr_pkg::cmd_t  cmd;
  btrr_pkg::stat_t stat;

  btrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .char_code (char_code),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  btrr_datapath #(
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .GLYPH_COUNT    (GLYPH_COUNT),
    .COORD_BITS     (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .font_addr  (font_addr),
    .font_byte  (font_byte),
    .start_x    (start_x),
    .start_y    (start_y),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_y      (row_y),
    .row_x      (row_x),
    .pixel_mask (pixel_mask),
    .color      (color),
    .last_row   (last_row)
  );

  // ready only once the read stage has emptied
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !stat.pipe_busy)
    else $error("input ready while a row read is in flight");

  // a drawable character blocks the input in the next cycle
  a_capture_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> in_stall)
    else $error("input not stalled after character request");

  // rows are only read while the controller walks a character
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_en |-> in_stall)
    else $error("row read outside a character");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid right after reset");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [1:0]  op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [7:0]  code;
  } req_t;

  typedef struct {
    logic [11:0] y;
    logic [15:0] x;
    logic [15:0] mask;
    logic [31:0] ink;
    logic        last;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [12:0] font_addr = '0;
  logic [7:0] font_byte = '0;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic [7:0] char_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] row_y;
  logic signed [15:0] row_x;
  logic [15:0] pixel_mask;
  logic [31:0] color;
  logic last_row;

  bitmap_text_row_renderer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .font_addr(font_addr), .font_byte(font_byte),
    .start_x(start_x), .start_y(start_y), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_y(row_y), .row_x(row_x), .pixel_mask(pixel_mask),
    .color(color), .last_row(last_row)
  );

  // predictor state
  logic [7:0]  glyph_mem [0:btrr_pkg::STORE_DEPTH-1];
  logic [15:0] pen_x = '0, pen_y = '0, margin_x = '0;
  logic [4:0]  font_h = btrr_pkg::RST_FONT_HEIGHT;
  logic [4:0]  font_w = btrr_pkg::RST_FONT_WIDTH;
  logic [12:0] scr_w = btrr_pkg::RST_SCREEN_WIDTH;
  logic [12:0] scr_h = btrr_pkg::RST_SCREEN_HEIGHT;
  logic [31:0] ink = btrr_pkg::RST_INK_COLOR;

  // stimulus side: glyph bytes already queued for loading
  bit          glyph_ready [0:btrr_pkg::STORE_DEPTH-1];
  logic [7:0]  draw_code = 8'd65;

  req_t pending_reqs[$];
  row_t rows_due[$];
  req_t cur_req;

  int send_idle_pct = 13;
  int recv_idle_pct = 82;
  logic hold_go = 1'b0;
  int hold_left = 0;

  int error_count = 0;
  int reqs_taken = 0;
  int chars_taken = 0;
  int rows_checked = 0;
  int settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic render_request(input req_t q);
    row_t fresh[$];
    row_t rr;
    int rows, x0, y0, yy, col, a;
    logic [12:0] a0, a1;
    logic [15:0] m;
    case (q.op)
      btrr_pkg::OP_LOAD: glyph_mem[q.addr] = q.data;
      btrr_pkg::OP_START: begin
        pen_x = q.sx;
        pen_y = q.sy;
        margin_x = q.sx;
      end
      btrr_pkg::OP_CHAR: begin
        chars_taken++;
        if (q.code == btrr_pkg::NEWLINE_CODE) begin
          pen_x = margin_x;
          pen_y = pen_y + {11'd0, font_h};
        end else begin
          if (font_w <= btrr_pkg::WIDE_LIMIT && int'(q.code) < btrr_pkg::DEF_GLYPH_COUNT) begin
            rows = (font_h > btrr_pkg::ROW_LIMIT) ? btrr_pkg::ROW_LIMIT : int'(font_h);
            x0 = int'($signed(pen_x));
            y0 = int'($signed(pen_y));
            for (int r = 0; r < rows; r++) begin
              yy = y0 + r;
              if (yy < 0 || yy >= int'(scr_h) || yy > 4095) continue;
              if (font_w > btrr_pkg::NARROW_LIMIT) begin
                a = int'(q.code) * int'(font_h) * 2 + 2 * r;
                a0 = a[12:0];
                a1 = a0 + 13'd1;
                m = {glyph_mem[a0], glyph_mem[a1]};
              end else begin
                a = int'(q.code) * int'(font_h) + r;
                a0 = a[12:0];
                m = {glyph_mem[a0], 8'h00};
              end
              for (int i = 0; i < 16; i++) begin
                col = x0 + i;
                if (col < 0 || col >= int'(scr_w)) m[15-i] = 1'b0;
              end
              rr.y = yy[11:0];
              rr.x = pen_x;
              rr.mask = m;
              rr.ink = ink;
              rr.last = 1'b0;
              fresh.push_back(rr);
            end
            if (fresh.size() != 0) fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[k]) rows_due.push_back(fresh[k]);
          end
          pen_x = pen_x + {11'd0, font_w};
        end
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk) begin : drive_proc
    req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        render_request(cur_req);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          cur_req = nxt;
          operation <= nxt.op;
          font_addr <= nxt.addr;
          font_byte <= nxt.data;
          start_x <= nxt.sx;
          start_y <= nxt.sy;
          char_code <= nxt.code;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    row_t e;
    if (!rst && out_valid && !out_stall) begin
      if (rows_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected row: y=%0d x=%0d mask=%h color=%h last=%b",
                   row_y, row_x, pixel_mask, color, last_row);
      end else begin
        e = rows_due.pop_front();
        rows_checked++;
        if (row_y !== e.y || row_x !== e.x || pixel_mask !== e.mask ||
            color !== e.ink || last_row !== e.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("row mismatch: exp y=%0d x=%0d mask=%h color=%h last=%b",
                     e.y, $signed(e.x), e.mask, e.ink, e.last);
            $display("              got y=%0d x=%0d mask=%h color=%h last=%b",
                     row_y, row_x, pixel_mask, color, last_row);
          end
        end
      end
    end
  end

  function automatic req_t mk(input logic [1:0] op, input logic [12:0] addr,
                              input logic [7:0] data, input logic [15:0] sx,
                              input logic [15:0] sy, input logic [7:0] code);
    req_t q;
    q.op = op;
    q.addr = addr;
    q.data = data;
    q.sx = sx;
    q.sy = sy;
    q.code = code;
    return q;
  endfunction

  function automatic req_t start_near();
    req_t q;
    int span_x, span_y, vx, vy;
    q = mk(btrr_pkg::OP_START, 13'($urandom), 8'($urandom), 16'($urandom),
           16'($urandom), 8'($urandom));
    // mostly land near the visible area so rows get through
    if ($urandom_range(99) < 75) begin
      span_x = (scr_w > 4096) ? 4096 : int'(scr_w);
      span_y = (scr_h > 4096) ? 4096 : int'(scr_h);
      vx = $urandom_range(span_x + 40) - 20;
      vy = $urandom_range(span_y + 40) - 20;
      q.sx = vx[15:0];
      q.sy = vy[15:0];
    end
    return q;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int k;
    q = mk(btrr_pkg::OP_CHAR, 13'($urandom), 8'($urandom), 16'($urandom),
           16'($urandom), draw_code);
    k = $urandom_range(99);
    if (k < 60) begin
      // any code is safe when no glyph row gets read
      if (font_w > btrr_pkg::WIDE_LIMIT || font_h == 5'd0) q.code = 8'($urandom);
    end
    else if (k < 70) q.code = btrr_pkg::NEWLINE_CODE;
    else if (k < 82) q = start_near();
    else if (k < 94) q.op = btrr_pkg::OP_LOAD;
    else q.op = OP_UNUSED;
    return q;
  endfunction

  // queue loads for every glyph byte the given code reads at the current font size
  task automatic load_glyph(input logic [7:0] c);
    int rows, a;
    logic [12:0] a0;
    @(negedge clk);
    draw_code = c;
    if (font_w <= btrr_pkg::WIDE_LIMIT && font_h != 5'd0) begin
      rows = (font_h > btrr_pkg::ROW_LIMIT) ? btrr_pkg::ROW_LIMIT : int'(font_h);
      for (int r = 0; r < rows; r++) begin
        for (int b = 0; b < 2; b++) begin
          if (font_w > btrr_pkg::NARROW_LIMIT) a = int'(c) * int'(font_h) * 2 + 2 * r + b;
          else a = int'(c) * int'(font_h) + r;
          a0 = a[12:0];
          if (!glyph_ready[a0]) begin
            glyph_ready[a0] = 1'b1;
            pending_reqs.push_back(mk(btrr_pkg::OP_LOAD, a0, 8'($urandom), 16'($urandom),
                                      16'($urandom), 8'($urandom)));
          end
        end
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || rows_due.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [4:0] h, input logic [4:0] w,
                               input logic [12:0] sw, input logic [12:0] sh,
                               input logic [31:0] c);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= btrr_pkg::REG_FONT_HEIGHT;
    cfg_data <= {27'd0, h};
    @(posedge clk);
    cfg_index <= btrr_pkg::REG_FONT_WIDTH;
    cfg_data <= {27'd0, w};
    @(posedge clk);
    cfg_index <= btrr_pkg::REG_SCREEN_WIDTH;
    cfg_data <= {19'd0, sw};
    @(posedge clk);
    cfg_index <= btrr_pkg::REG_SCREEN_HEIGHT;
    cfg_data <= {19'd0, sh};
    @(posedge clk);
    cfg_index <= btrr_pkg::REG_INK_COLOR;
    cfg_data <= c;
    @(posedge clk);
    cfg_write <= 1'b0;
    font_h = h;
    font_w = w;
    scr_w = sw;
    scr_h = sh;
    ink = c;
    settings_used++;
  endtask

  task automatic run_phase(input int n);
    @(negedge clk);
    pending_reqs.push_back(start_near());
    repeat (n - 1) pending_reqs.push_back(rand_req());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed requests at reset register values
    load_glyph(8'd65);
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0,
                              btrr_pkg::NEWLINE_CODE));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(OP_UNUSED, 13'h1FFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    // partly off the left and top edges
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, -16'sd4, -16'sd3, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    // partly off the right and bottom edges
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'd636, 16'd475, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    // cursor wraps past the top of the coordinate range
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'h7FFF, 16'h7FFF, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'h8000, 16'h8000, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0,
                              btrr_pkg::NEWLINE_CODE));
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'hFFF0, 16'h01D8, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    drain();
    run_phase(8);
    drain();

    // smallest screen and font
    apply_setting(5'd1, 5'd1, 13'd1, 13'd1, 32'h0000_0000);
    load_glyph(8'd0);
    run_phase(6);
    drain();

    // wide font on a 4096 by 4096 screen
    apply_setting(5'd16, 5'd16, 13'd4096, 13'd4096, 32'h1234_5678);
    load_glyph(8'd4);
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    run_phase(6);
    drain();

    send_idle_pct = 82;
    recv_idle_pct = 13;
    // widest font draws nothing, tallest step
    apply_setting(5'd31, 5'd31, 13'd8191, 13'd8191, 32'hFFFF_FFFF);
    run_phase(6);
    drain();

    // zero height and zero width
    apply_setting(5'd0, 5'd0, 13'd0, 13'd0, 32'h8000_0001);
    run_phase(5);
    drain();

    // tall wide font, glyph addresses wrap onto the bytes loaded for the wide font
    apply_setting(5'd20, 5'd12, 13'($urandom_range(1, 4096)),
                  13'($urandom_range(1, 4096)), $urandom);
    load_glyph(8'd208);
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'd2, 16'd2, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    run_phase(6);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(5'($urandom_range(1, 8)), 5'($urandom_range(9, 16)),
                  13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), $urandom);
    load_glyph(8'd100);
    pending_reqs.push_back(mk(btrr_pkg::OP_START, 13'd0, 8'd0, 16'd0, 16'd0, 8'd0));
    pending_reqs.push_back(mk(btrr_pkg::OP_CHAR, 13'd0, 8'd0, 16'd0, 16'd0, draw_code));
    run_phase(10);
    // hold the output long enough for the input to back up
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    drain();

    apply_setting(5'($urandom_range(1, 8)), 5'($urandom_range(1, 8)),
                  13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), $urandom);
    load_glyph(8'd255);
    run_phase(6);
    drain();

    $display("covered %0d requests (%0d character requests) under %0d register settings",
             reqs_taken, chars_taken, settings_used);
    $display("%0d rows compared, %0d errors", rows_checked, error_count);
    if (error_count == 0 && rows_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d rows still due", rows_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
